FILE: sv/kss_pkg.sv
// shared types and constants for the k-th smallest selection block
// no dependencies; imported by kth_smallest_select_top
`default_nettype none

package kss_pkg;

    localparam int SAMPLE_W = 16;
    localparam int RANK_W   = 6;

    typedef enum logic [1:0] {
        S_LOAD,
        S_SCAN,
        S_WAIT,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

FILE: sv/kss_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module kss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                     i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: sv/kth_smallest_select_top.sv
// k-th smallest selection: sample buffer plus bitwise radix select sequencer
// depends on kss_pkg and kss_ram
//
// usage
//   input channel (i_valid / o_stall): one item carries one 16-bit sample; the
//   item with i_last high closes the set and carries i_rank, the wanted
//   position in ascending order counted from 0
//   output channel (o_valid / i_stall): one item per closed set with the
//   selected sample, o_rank_error (rank not below sample count, value then 0)
//   and o_overflow (samples beyond DEPTH were dropped)
// throughput and sequence
//   samples load at one item per cycle while the block is collecting
//   after the last item the block resolves the answer one bit per pass,
//   msb first: 16 passes over the n stored samples, each pass reading every
//   sample in turn through the single ram read port and one shared
//   compare/count unit, then a wait state that resolves the bit of that pass
//   a rank error skips the passes and shows the result on the next cycle
//   o_stall is high from the last item until the result is taken
// reset and backpressure
//   synchronous active-low reset empties the set and clears the overflow mark;
//   buffer contents are not cleared, only entries of the current set are read
//   the result holds steady on the outputs while i_stall is high; the next
//   set is accepted only after the result has been taken
`default_nettype none

module kth_smallest_select_top #(
    parameter int DEPTH = 64
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [kss_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic                         i_last,
    input  wire logic [kss_pkg::RANK_W-1:0]   i_rank,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic      [kss_pkg::SAMPLE_W-1:0] o_selected,
    output logic                              o_rank_error,
    output logic                              o_overflow
);

    import kss_pkg::*;

    // count holds 0..DEPTH, address holds 0..DEPTH-1
    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // compare width for rank against a count
    localparam int KW = (CW > RANK_W) ? CW : RANK_W;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;       // samples stored in this set
    logic                r_ovf, n_ovf;           // a sample was dropped
    logic [AW-1:0]       r_addr, n_addr;         // scan read address
    logic                r_rd_vld, n_rd_vld;     // ram data holds a scanned sample
    logic [CW-1:0]       r_zeros, n_zeros;       // matches with current bit clear
    logic [RANK_W-1:0]   r_k, n_k;               // rank left within current prefix
    logic [SAMPLE_W-1:0] r_prefix, n_prefix;     // answer bits resolved so far
    logic [SAMPLE_W-1:0] r_mask, n_mask;         // which prefix bits are resolved
    logic [SAMPLE_W-1:0] r_sel, n_sel;           // one-hot bit under test
    logic [SAMPLE_W-1:0] r_selected, n_selected;
    logic                r_err, n_err;

    logic                ram_we;
    logic [SAMPLE_W-1:0] ram_rdata;
    logic                full;
    logic                match;
    logic [CW-1:0]       total;
    logic [CW-1:0]       count_inc;

    kss_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_sample),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    assign full      = (r_count == CW'(DEPTH));
    assign count_inc = full ? r_count : r_count + CW'(1);

    // shared compare unit: sample agrees with resolved prefix and has the
    // bit under test clear
    assign match = (((ram_rdata ^ r_prefix) & r_mask) == '0) && ((ram_rdata & r_sel) == '0);
    assign total = r_zeros + CW'(match);

    assign o_stall      = (r_state != S_LOAD);
    assign o_valid      = (r_state == S_OUT);
    assign o_selected   = r_selected;
    assign o_rank_error = r_err;
    assign o_overflow   = r_ovf;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_ovf      = r_ovf;
        n_addr     = r_addr;
        n_rd_vld   = 1'b0;
        n_zeros    = r_zeros;
        n_k        = r_k;
        n_prefix   = r_prefix;
        n_mask     = r_mask;
        n_sel      = r_sel;
        n_selected = r_selected;
        n_err      = r_err;
        ram_we     = 1'b0;

        unique case (r_state)
            S_LOAD: begin
                if (i_valid) begin
                    ram_we  = !full;
                    n_count = count_inc;
                    n_ovf   = r_ovf | full;
                    if (i_last) begin
                        if (KW'(i_rank) < KW'(count_inc)) begin
                            n_state  = S_SCAN;
                            n_addr   = '0;
                            n_zeros  = '0;
                            n_k      = i_rank;
                            n_prefix = '0;
                            n_mask   = '0;
                            n_sel    = {1'b1, {(SAMPLE_W-1){1'b0}}};
                            n_err    = 1'b0;
                        end else begin
                            n_state    = S_OUT;
                            n_selected = '0;
                            n_err      = 1'b1;
                        end
                    end
                end
            end
            S_SCAN: begin
                // issue one read per cycle, count the sample read last cycle
                n_rd_vld = 1'b1;
                if (r_rd_vld) begin
                    n_zeros = total;
                end
                if (CW'(r_addr) == r_count - CW'(1)) begin
                    n_state = S_WAIT;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_WAIT: begin
                // last sample of the pass is here: resolve one answer bit
                if (KW'(r_k) >= KW'(total)) begin
                    n_k      = r_k - RANK_W'(total);
                    n_prefix = r_prefix | r_sel;
                end
                n_mask = r_mask | r_sel;
                n_sel  = r_sel >> 1;
                if (r_sel[0]) begin
                    n_state    = S_OUT;
                    n_selected = (KW'(r_k) >= KW'(total)) ? (r_prefix | r_sel) : r_prefix;
                end else begin
                    n_state = S_SCAN;
                    n_addr  = '0;
                    n_zeros = '0;
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_LOAD;
                    n_count = '0;
                    n_ovf   = 1'b0;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_rd_vld <= n_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_zeros    <= n_zeros;
        r_k        <= n_k;
        r_prefix   <= n_prefix;
        r_mask     <= n_mask;
        r_sel      <= n_sel;
        r_selected <= n_selected;
        r_err      <= n_err;
    end

endmodule

`default_nettype wire
